// ===== hdl/uart_link_frame_parser_assert.svh =====
// Assertion macros for the frame parser.
`ifndef UART_LINK_FRAME_PARSER_ASSERT_SVH
`define UART_LINK_FRAME_PARSER_ASSERT_SVH

// checked only out of reset
`define ULFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define ULFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== hdl/ulfp_pkg.sv =====
`timescale 1ns / 1ps

package ulfp_pkg;

  localparam int unsigned SyncLen    = 8;
  localparam int unsigned SyncPosW   = 3;
  localparam int unsigned MacLen     = 6;
  localparam int unsigned SsidLen    = 32;
  localparam int unsigned SsidPosW   = 6;
  localparam int unsigned OldFwLimit = 10;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CfgSyncPattern    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTypeDeviceInfo = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTypePacket     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTypeScanEntry  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTypeScanCount  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgExpectedVer    = 3'd5;

  localparam logic [3:0] EvNone     = 4'd0;
  localparam logic [3:0] EvUnknown  = 4'd1;
  localparam logic [3:0] EvDevInfo  = 4'd2;
  localparam logic [3:0] EvLink     = 4'd3;
  localparam logic [3:0] EvApCount  = 4'd4;
  localparam logic [3:0] EvSsidByte = 4'd5;
  localparam logic [3:0] EvApEnd    = 4'd6;
  localparam logic [3:0] EvPayload  = 4'd7;
  localparam logic [3:0] EvPong     = 4'd8;

  typedef struct packed {
    logic [63:0] sync_pattern;
    logic [7:0]  type_device_info;
    logic [7:0]  type_packet;
    logic [7:0]  type_scan_entry;
    logic [7:0]  type_scan_count;
    logic [7:0]  expected_version;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]        event_res;
    logic [7:0]        data_byte;
    logic              last;
    logic [47:0]       mac_address;
    logic [7:0]        fw_ver;
    logic              version_ok;
    logic              link_up;
    logic signed [7:0] rssi_dbm;
    logic [7:0]        ap_num;
    logic [7:0]        ap_total;
    logic              needs_password;
  } out_t;

endpackage

// ===== hdl/uart_link_frame_parser.sv =====
// Channel  Direction  Handshake                 Beat
// in       input      in_valid_i / in_stall_o   in_data_i  (cmd, rx_byte)
// out      output     out_valid_o / out_stall_i out_data_o (one result per input beat)
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One input beat per cycle while in_stall_o is low; results go to out_q or skid_q.
// Rate is set by the parser state registers and the two-entry output buffer.
// in_stall_o comes only from the skid entry flop, so there is no stall path
// from out_stall_i to in_stall_o. Under output stall one extra beat is absorbed.
// rst_ni is asynchronous, active low; parser and config return to reset values.
`timescale 1ns / 1ps
`include "uart_link_frame_parser_assert.svh"

module uart_link_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ulfp_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ulfp_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [ulfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ulfp_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import ulfp_pkg::*;

  cfg_t cfg;
  out_t res;
  logic in_acc;
  logic out_pop;
  logic out_free;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  out_t out_q;
  out_t skid_q;

  ulfp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ulfp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (in_acc),
    .item_i (in_data_i),
    .res_o  (res)
  );

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_pop    = out_valid_q && !out_stall_i;
  assign out_free   = out_pop || !out_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_acc;
      end
    end else if (in_acc) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end
    if (!out_free && in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ULFP_ASSERT_ALWAYS(a_skid_implies_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  `ULFP_ASSERT(a_stalled_beat_to_skid, (in_acc && out_valid_q && out_stall_i) |=> skid_valid_q, "beat lost under stall")
  `ULFP_ASSERT(a_skid_drains, (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q), "skid beat not moved to output")

endmodule

// ===== hdl/ulfp_cfg.sv =====
`timescale 1ns / 1ps

module ulfp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ulfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ulfp_pkg::CfgDataW-1:0] cfg_wdata_i,
  output ulfp_pkg::cfg_t                cfg_o
);
  import ulfp_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSyncPattern:    cfg_d.sync_pattern     = cfg_wdata_i;
        CfgTypeDeviceInfo: cfg_d.type_device_info = cfg_wdata_i[7:0];
        CfgTypePacket:     cfg_d.type_packet      = cfg_wdata_i[7:0];
        CfgTypeScanEntry:  cfg_d.type_scan_entry  = cfg_wdata_i[7:0];
        CfgTypeScanCount:  cfg_d.type_scan_count  = cfg_wdata_i[7:0];
        CfgExpectedVer:    cfg_d.expected_version = cfg_wdata_i[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_pattern     <= '0;
      cfg_q.type_device_info <= 8'd1;
      cfg_q.type_packet      <= 8'd2;
      cfg_q.type_scan_entry  <= 8'd3;
      cfg_q.type_scan_count  <= 8'd4;
      cfg_q.expected_version <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/ulfp_parser.sv =====
`timescale 1ns / 1ps

module ulfp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ulfp_pkg::cfg_t cfg_i,
  input  logic           step_i,
  input  ulfp_pkg::in_t  item_i,
  output ulfp_pkg::out_t res_o
);
  import ulfp_pkg::*;

  typedef enum logic [7:0] {
    PhHunt    = 8'b0000_0001,
    PhType    = 8'b0000_0010,
    PhParam   = 8'b0000_0100,
    PhLenHi   = 8'b0000_1000,
    PhLenLo   = 8'b0001_0000,
    PhMac     = 8'b0010_0000,
    PhAp      = 8'b0100_0000,
    PhPayload = 8'b1000_0000
  } phase_e;

  typedef enum logic [2:0] {
    KindNone      = 3'd0,
    KindDev       = 3'd1,
    KindPkt       = 3'd2,
    KindScanEntry = 3'd3,
    KindScanCount = 3'd4
  } kind_e;

  function automatic kind_e kind_of(logic [7:0] t, cfg_t c);
    kind_e k;
    if (t == c.type_device_info)     k = KindDev;
    else if (t == c.type_packet)     k = KindPkt;
    else if (t == c.type_scan_entry) k = KindScanEntry;
    else if (t == c.type_scan_count) k = KindScanCount;
    else                             k = KindNone;
    return k;
  endfunction

  phase_e              phase_q, phase_d;
  logic [SyncPosW-1:0] sync_pos_q, sync_pos_d;
  logic [7:0]          frame_type_q, frame_type_d;
  logic [15:0]         frame_length_q, frame_length_d;
  logic [15:0]         byte_count_q, byte_count_d;
  logic [47:0]         mac_q, mac_d;
  logic [7:0]          version_q, version_d;
  logic [7:0]          ap_slot_q, ap_slot_d;
  logic [SsidPosW-1:0] ssid_pos_q, ssid_pos_d;

  logic [7:0]  b;
  logic [7:0]  sync_byte;
  logic [15:0] byte_count_inc;
  logic [15:0] length_full;
  kind_e       kind_rx;
  kind_e       kind_frame;
  out_t        res;

  assign b              = item_i.rx_byte;
  assign sync_byte      = cfg_i.sync_pattern[{sync_pos_q, 3'b000} +: 8];
  assign byte_count_inc = byte_count_q + 16'd1;
  assign length_full    = {frame_length_q[15:8], b};
  assign kind_rx        = kind_of(b, cfg_i);
  assign kind_frame     = kind_of(frame_type_q, cfg_i);

  always_comb begin
    phase_d        = phase_q;
    sync_pos_d     = sync_pos_q;
    frame_type_d   = frame_type_q;
    frame_length_d = frame_length_q;
    byte_count_d   = byte_count_q;
    mac_d          = mac_q;
    version_d      = version_q;
    ap_slot_d      = ap_slot_q;
    ssid_pos_d     = ssid_pos_q;
    res            = '0;

    if (item_i.cmd) begin
      phase_d        = PhHunt;
      sync_pos_d     = '0;
      byte_count_d   = '0;
      ssid_pos_d     = '0;
      frame_length_d = '0;
    end else begin
      case (phase_q)
        PhType: begin
          frame_type_d = b;
          if (kind_rx == KindNone) begin
            res.event_res = EvUnknown;
            phase_d       = PhHunt;
          end else begin
            phase_d = PhParam;
          end
        end
        PhParam: begin
          phase_d = PhLenHi;
          case (kind_frame)
            KindDev: begin
              version_d = b;
              if (b < 8'(OldFwLimit)) begin
                res.event_res   = EvDevInfo;
                res.mac_address = mac_q;
                res.fw_ver      = b;
                res.version_ok  = (b == cfg_i.expected_version);
                phase_d         = PhHunt;
              end
            end
            KindPkt: begin
              res.event_res = EvLink;
              res.link_up   = (b != 8'd0);
              res.rssi_dbm  = b[7] ? $signed(b) : 8'sd0;
            end
            KindScanEntry: ap_slot_d = b;
            KindScanCount: begin
              res.event_res = EvApCount;
              res.ap_total  = b;
            end
            default: phase_d = PhHunt;
          endcase
        end
        PhLenHi: begin
          frame_length_d = {b, 8'd0};
          phase_d        = PhLenLo;
        end
        PhLenLo: begin
          frame_length_d = length_full;
          byte_count_d   = '0;
          ssid_pos_d     = '0;
          if (kind_frame == KindDev) begin
            phase_d = PhMac;
          end else if (kind_frame == KindScanEntry) begin
            phase_d = PhAp;
          end else if (kind_frame == KindPkt && length_full != 16'd0) begin
            phase_d = PhPayload;
          end else begin
            if (kind_frame == KindPkt) begin
              res.event_res = EvPong;
            end
            phase_d = PhHunt;
          end
        end
        PhMac: begin
          mac_d        = {mac_q[39:0], b};
          byte_count_d = byte_count_inc;
          if (byte_count_inc >= 16'(MacLen)) begin
            byte_count_d    = '0;
            res.event_res   = EvDevInfo;
            res.mac_address = {mac_q[39:0], b};
            res.fw_ver      = version_q;
            res.version_ok  = (version_q == cfg_i.expected_version);
            phase_d         = PhHunt;
          end
        end
        PhAp: begin
          res.ap_num = ap_slot_q;
          if (ssid_pos_q < SsidPosW'(SsidLen)) begin
            res.event_res = EvSsidByte;
            res.data_byte = b;
            ssid_pos_d    = ssid_pos_q + 1'b1;
          end else begin
            res.event_res      = EvApEnd;
            res.last           = 1'b1;
            res.needs_password = (b != 8'd0);
            ssid_pos_d         = '0;
            phase_d            = PhHunt;
          end
        end
        PhPayload: begin
          res.event_res = EvPayload;
          res.data_byte = b;
          byte_count_d  = byte_count_inc;
          if (byte_count_inc >= frame_length_q) begin
            res.last     = 1'b1;
            byte_count_d = '0;
            phase_d      = PhHunt;
          end
        end
        default: begin
          phase_d = PhHunt;
          if (b == sync_byte) begin
            sync_pos_d = sync_pos_q + 1'b1;
            if (sync_pos_q == SyncPosW'(SyncLen - 1)) begin
              sync_pos_d = '0;
              phase_d    = PhType;
            end
          end else begin
            sync_pos_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhHunt;
      sync_pos_q     <= '0;
      frame_type_q   <= '0;
      frame_length_q <= '0;
      byte_count_q   <= '0;
      mac_q          <= '0;
      version_q      <= '0;
      ap_slot_q      <= '0;
      ssid_pos_q     <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      sync_pos_q     <= sync_pos_d;
      frame_type_q   <= frame_type_d;
      frame_length_q <= frame_length_d;
      byte_count_q   <= byte_count_d;
      mac_q          <= mac_d;
      version_q      <= version_d;
      ap_slot_q      <= ap_slot_d;
      ssid_pos_q     <= ssid_pos_d;
    end
  end

  assign res_o = res;

endmodule
